FILE: src/mrx_pkg.sv
// ----------------------------------------------------------------------------
// mrx_pkg
// Shared types, sizes and helpers of the multi-rail XOR list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mrx_pkg;

    localparam int NUM_RAILS   = 16;
    localparam int POOL_NODES  = 1024;
    localparam int VALUE_BITS  = 32;

    localparam int RAIL_W      = (NUM_RAILS > 1) ? $clog2(NUM_RAILS) : 1;
    localparam int NODE_W      = $clog2(POOL_NODES);
    localparam int FRESH_W     = NODE_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_ENTER   = 2'd0,
        ACT_LEAVE   = 2'd1,
        ACT_MIGRATE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_POP_EMPTY = 3'd1,
        ST_POOL_FULL = 3'd2,
        ST_SRC_EMPTY = 3'd3,
        ST_SAME_RAIL = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RD1,
        BK_RD2,
        BK_EXE,
        BK_W2,
        BK_DONE
    } bk_state_t;

    typedef struct packed {
        action_t                 action;
        logic [RAIL_W-1:0]       rail_a;
        logic [RAIL_W-1:0]       rail_b;
        logic                    same_rail;
        logic [VALUE_BITS-1:0]   value;
    } cmd_t;

    // Reduce a 4-bit rail number modulo NUM_RAILS by repeated subtraction.
    function automatic logic [RAIL_W-1:0] rail_mod(input logic [3:0] x);
        logic [8:0] r;
        r = {5'd0, x};
        for (int i = 0; i < 8; i++)
        begin
            if (r >= 9'(NUM_RAILS))
            begin
                r = r - 9'(NUM_RAILS);
            end
        end
        return RAIL_W'(r);
    endfunction

endpackage

`default_nettype wire

FILE: src/mrx_ram.sv
// ----------------------------------------------------------------------------
// mrx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/mrx_front.sv
// ----------------------------------------------------------------------------
// mrx_front
// Accepts items, reduces rail numbers and flags same-rail migrates.
// ----------------------------------------------------------------------------
`default_nettype none

module mrx_front (
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [3:0]  rail_a,
    input  wire logic [3:0]  rail_b,
    input  wire logic signed [31:0] item_value,
    output logic             push,
    output mrx_pkg::cmd_t    push_cmd,
    input  wire logic        q_full
);

    logic [mrx_pkg::RAIL_W-1:0] a_red;
    logic [mrx_pkg::RAIL_W-1:0] b_red;

    always_comb
    begin
        a_red              = mrx_pkg::rail_mod(rail_a);
        b_red              = mrx_pkg::rail_mod(rail_b);
        in_ready           = !q_full;
        push               = in_valid && !q_full;
        push_cmd.action    = mrx_pkg::action_t'(action);
        push_cmd.rail_a    = a_red;
        push_cmd.rail_b    = b_red;
        push_cmd.same_rail = (a_red == b_red);
        push_cmd.value     = mrx_pkg::VALUE_BITS'($unsigned(item_value));
    end

endmodule

`default_nettype wire

FILE: src/mrx_queue.sv
// ----------------------------------------------------------------------------
// mrx_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module mrx_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  mrx_pkg::cmd_t      push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               q_valid,
    output mrx_pkg::cmd_t      q_cmd
);

    mrx_pkg::cmd_t               entry_reg [mrx_pkg::QUEUE_DEPTH];
    logic [mrx_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mrx_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mrx_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                        do_pop;

    always_comb
    begin
        full    = (count_reg == mrx_pkg::QCNT_W'(mrx_pkg::QUEUE_DEPTH));
        q_valid = (count_reg != '0);
        q_cmd   = entry_reg[rd_ptr_reg];
        do_pop  = pop && q_valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == mrx_pkg::QPTR_W'(mrx_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mrx_pkg::QPTR_W'(mrx_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: src/mrx_back.sv
// ----------------------------------------------------------------------------
// mrx_back
// Executes queued commands against the node pool and rail head/tail tables.
// ----------------------------------------------------------------------------
`default_nettype none

module mrx_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  mrx_pkg::cmd_t      q_cmd,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [2:0]         status,
    output logic               popped_valid,
    output logic signed [31:0] popped_value
);

    localparam int NW = mrx_pkg::NODE_W;
    localparam int RW = mrx_pkg::RAIL_W;
    localparam int VB = mrx_pkg::VALUE_BITS;

    mrx_pkg::bk_state_t state_reg, state_next;
    mrx_pkg::cmd_t      cmd_reg, cmd_next;

    logic [NW-1:0] ha_reg, ha_next;
    logic [NW-1:0] ta_reg, ta_next;
    logic [NW-1:0] tb_reg, tb_next;
    logic [NW-1:0] link_fh_reg, link_fh_next;
    logic [NW-1:0] link_ta_reg, link_ta_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] free_head_reg, free_head_next;
    logic [mrx_pkg::FRESH_W-1:0] fresh_reg, fresh_next;

    mrx_pkg::status_t res_status_reg, res_status_next;
    logic             res_pvalid_reg, res_pvalid_next;
    logic [31:0]      res_pvalue_reg, res_pvalue_next;

    logic             out_valid_reg, out_valid_next;
    logic [2:0]       out_status_reg, out_status_next;
    logic             out_pvalid_reg, out_pvalid_next;
    logic [31:0]      out_pvalue_reg, out_pvalue_next;

    logic [mrx_pkg::NUM_RAILS-1:0] head_vld_reg, head_vld_next;
    logic [mrx_pkg::NUM_RAILS-1:0] tail_vld_reg, tail_vld_next;
    logic                          head_rv_reg, tail_rv_reg;

    // RAM ports
    logic          head_we,  tail_we,  link_we,  data_we;
    logic [RW-1:0] head_waddr, head_raddr, tail_waddr, tail_raddr;
    logic [NW-1:0] head_wdata, tail_wdata, head_rdata, tail_rdata;
    logic [NW-1:0] link_waddr, link_raddr, link_wdata, link_rdata;
    logic [NW-1:0] data_waddr, data_raddr;
    logic [VB-1:0] data_wdata, data_rdata;

    logic [NW-1:0] head_val, tail_val;
    logic [NW-1:0] n_sel;
    logic [63:0]   data_ext;

    mrx_ram #(.WIDTH(NW), .DEPTH(mrx_pkg::NUM_RAILS)) u_head (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );

    mrx_ram #(.WIDTH(NW), .DEPTH(mrx_pkg::NUM_RAILS)) u_tail (
        .clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
        .raddr(tail_raddr), .rdata(tail_rdata)
    );

    mrx_ram #(.WIDTH(NW), .DEPTH(mrx_pkg::POOL_NODES)) u_link (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_rdata)
    );

    mrx_ram #(.WIDTH(VB), .DEPTH(mrx_pkg::POOL_NODES)) u_data (
        .clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
        .raddr(data_raddr), .rdata(data_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign popped_valid = out_pvalid_reg;
    assign popped_value = out_pvalue_reg;

    always_comb
    begin
        // rail entries never written read as empty
        head_val = head_rv_reg ? head_rdata : '0;
        tail_val = tail_rv_reg ? tail_rdata : '0;
        data_ext = 64'($signed(data_rdata));

        state_next       = state_reg;
        cmd_next         = cmd_reg;
        ha_next          = ha_reg;
        ta_next          = ta_reg;
        tb_next          = tb_reg;
        link_fh_next     = link_fh_reg;
        link_ta_next     = link_ta_reg;
        n_next           = n_reg;
        free_head_next   = free_head_reg;
        fresh_next       = fresh_reg;
        res_status_next  = res_status_reg;
        res_pvalid_next  = res_pvalid_reg;
        res_pvalue_next  = res_pvalue_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_status_next  = out_status_reg;
        out_pvalid_next  = out_pvalid_reg;
        out_pvalue_next  = out_pvalue_reg;
        q_pop            = 1'b0;
        n_sel            = '0;

        head_we    = 1'b0;
        head_waddr = cmd_reg.rail_a;
        head_wdata = '0;
        head_raddr = cmd_reg.rail_a;
        tail_we    = 1'b0;
        tail_waddr = cmd_reg.rail_a;
        tail_wdata = '0;
        tail_raddr = cmd_reg.rail_a;
        link_we    = 1'b0;
        link_waddr = ta_reg;
        link_wdata = '0;
        link_raddr = free_head_reg;
        data_we    = 1'b0;
        data_waddr = '0;
        data_wdata = cmd_reg.value;
        data_raddr = ta_reg;

        case (state_reg)
            mrx_pkg::BK_IDLE:
            begin
                res_status_next = mrx_pkg::ST_OK;
                res_pvalid_next = 1'b0;
                res_pvalue_next = '0;
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = mrx_pkg::BK_RD1;
                end
            end

            mrx_pkg::BK_RD1:
            begin
                if (cmd_reg.action == mrx_pkg::ACT_NONE)
                begin
                    state_next = mrx_pkg::BK_DONE;
                end
                else if (cmd_reg.action == mrx_pkg::ACT_MIGRATE && cmd_reg.same_rail)
                begin
                    res_status_next = mrx_pkg::ST_SAME_RAIL;
                    state_next      = mrx_pkg::BK_DONE;
                end
                else
                begin
                    state_next = mrx_pkg::BK_RD2;
                end
            end

            mrx_pkg::BK_RD2:
            begin
                ha_next      = head_val;
                ta_next      = tail_val;
                link_fh_next = link_rdata;
                tail_raddr   = cmd_reg.rail_b;
                link_raddr   = tail_val;
                data_raddr   = tail_val;
                state_next   = mrx_pkg::BK_EXE;
            end

            mrx_pkg::BK_EXE:
            begin
                link_ta_next = link_rdata;
                case (cmd_reg.action)
                    mrx_pkg::ACT_ENTER:
                    begin
                        if (free_head_reg != '0)
                        begin
                            n_sel          = free_head_reg;
                            free_head_next = link_fh_reg;
                        end
                        else if (fresh_reg < mrx_pkg::FRESH_W'(mrx_pkg::POOL_NODES))
                        begin
                            n_sel      = fresh_reg[NW-1:0];
                            fresh_next = fresh_reg + 1'b1;
                        end
                        if (n_sel == '0)
                        begin
                            res_status_next = mrx_pkg::ST_POOL_FULL;
                            state_next      = mrx_pkg::BK_DONE;
                        end
                        else
                        begin
                            data_we    = 1'b1;
                            data_waddr = n_sel;
                            link_we    = 1'b1;
                            link_waddr = n_sel;
                            link_wdata = ta_reg;
                            tail_we    = 1'b1;
                            tail_wdata = n_sel;
                            n_next     = n_sel;
                            if (ta_reg == '0)
                            begin
                                head_we    = 1'b1;
                                head_wdata = n_sel;
                                state_next = mrx_pkg::BK_DONE;
                            end
                            else
                            begin
                                state_next = mrx_pkg::BK_W2;
                            end
                        end
                    end

                    mrx_pkg::ACT_LEAVE:
                    begin
                        if (ha_reg == '0 || ta_reg == '0)
                        begin
                            res_status_next = mrx_pkg::ST_POP_EMPTY;
                            state_next      = mrx_pkg::BK_DONE;
                        end
                        else
                        begin
                            res_pvalid_next = 1'b1;
                            res_pvalue_next = data_ext[31:0];
                            // push the freed node on the free chain
                            link_we         = 1'b1;
                            link_waddr      = ta_reg;
                            link_wdata      = free_head_reg;
                            free_head_next  = ta_reg;
                            tail_we         = 1'b1;
                            if (link_rdata != '0)
                            begin
                                tail_wdata = link_rdata;
                                link_raddr = link_rdata;
                                n_next     = link_rdata;
                                state_next = mrx_pkg::BK_W2;
                            end
                            else
                            begin
                                tail_wdata = '0;
                                head_we    = 1'b1;
                                head_wdata = '0;
                                state_next = mrx_pkg::BK_DONE;
                            end
                        end
                    end

                    mrx_pkg::ACT_MIGRATE:
                    begin
                        if (ha_reg == '0)
                        begin
                            res_status_next = mrx_pkg::ST_SRC_EMPTY;
                            state_next      = mrx_pkg::BK_DONE;
                        end
                        else
                        begin
                            tb_next    = tail_val;
                            link_we    = 1'b1;
                            link_waddr = ta_reg;
                            link_wdata = link_rdata ^ tail_val;
                            link_raddr = tail_val;
                            head_we    = 1'b1;
                            head_wdata = '0;
                            tail_we    = 1'b1;
                            tail_wdata = '0;
                            state_next = mrx_pkg::BK_W2;
                        end
                    end

                    default:
                    begin
                        state_next = mrx_pkg::BK_DONE;
                    end
                endcase
            end

            mrx_pkg::BK_W2:
            begin
                state_next = mrx_pkg::BK_DONE;
                case (cmd_reg.action)
                    mrx_pkg::ACT_ENTER:
                    begin
                        link_we    = 1'b1;
                        link_waddr = ta_reg;
                        link_wdata = link_ta_reg ^ n_reg;
                    end

                    mrx_pkg::ACT_LEAVE:
                    begin
                        link_we    = 1'b1;
                        link_waddr = n_reg;
                        link_wdata = link_rdata ^ ta_reg;
                    end

                    mrx_pkg::ACT_MIGRATE:
                    begin
                        tail_we    = 1'b1;
                        tail_waddr = cmd_reg.rail_b;
                        tail_wdata = ha_reg;
                        if (tb_reg == '0)
                        begin
                            head_we    = 1'b1;
                            head_waddr = cmd_reg.rail_b;
                            head_wdata = ta_reg;
                        end
                        else
                        begin
                            link_we    = 1'b1;
                            link_waddr = tb_reg;
                            link_wdata = link_rdata ^ ta_reg;
                        end
                    end

                    default:
                    begin
                        link_we = 1'b0;
                    end
                endcase
            end

            mrx_pkg::BK_DONE:
            begin
                // hold the result until the output register frees up
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pvalid_next = res_pvalid_reg;
                    out_pvalue_next = res_pvalue_reg;
                    state_next      = mrx_pkg::BK_IDLE;
                end
            end

            default:
            begin
                state_next = mrx_pkg::BK_IDLE;
            end
        endcase

        head_vld_next = head_vld_reg;
        tail_vld_next = tail_vld_reg;
        if (head_we)
        begin
            head_vld_next[head_waddr] = 1'b1;
        end
        if (tail_we)
        begin
            tail_vld_next[tail_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mrx_pkg::BK_IDLE;
            free_head_reg  <= '0;
            fresh_reg      <= mrx_pkg::FRESH_W'(1);
            out_valid_reg  <= 1'b0;
            head_vld_reg   <= '0;
            tail_vld_reg   <= '0;
            head_rv_reg    <= 1'b0;
            tail_rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            fresh_reg      <= fresh_next;
            out_valid_reg  <= out_valid_next;
            head_vld_reg   <= head_vld_next;
            tail_vld_reg   <= tail_vld_next;
            head_rv_reg    <= head_vld_reg[head_raddr];
            tail_rv_reg    <= tail_vld_reg[tail_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        ha_reg         <= ha_next;
        ta_reg         <= ta_next;
        tb_reg         <= tb_next;
        link_fh_reg    <= link_fh_next;
        link_ta_reg    <= link_ta_next;
        n_reg          <= n_next;
        res_status_reg <= res_status_next;
        res_pvalid_reg <= res_pvalid_next;
        res_pvalue_reg <= res_pvalue_next;
        out_status_reg <= out_status_next;
        out_pvalid_reg <= out_pvalid_next;
        out_pvalue_reg <= out_pvalue_next;
    end

endmodule

`default_nettype wire

FILE: src/multi_rail_xor_list_engine.sv
// ----------------------------------------------------------------------------
// multi_rail_xor_list_engine
// Stacks ("rails") built as XOR-linked lists in one shared node pool.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   input   | in        | in_valid / in_ready  | action, rail_a, rail_b, item_value
//   result  | out       | out_valid / out_ready| status, popped_valid, popped_value
//
// The back part steps read, read, execute, second write, result through one read
// and one write port of each of the link, data and head/tail memories; an item
// ends at execute when it needs no second write, and a same-rail migrate or the
// unused action goes from the first read straight to result.
// Reset empties every rail and the free chain; node memories need no clearing.
// A two-entry queue takes items while the back part works; a held result
// stalls the back part, and the input too once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_rail_xor_list_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         action,
    input  wire logic [3:0]         rail_a,
    input  wire logic [3:0]         rail_b,
    input  wire logic signed [31:0] item_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              status,
    output logic                    popped_valid,
    output logic signed [31:0]      popped_value
);

    logic          push;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    mrx_pkg::cmd_t push_cmd;
    mrx_pkg::cmd_t q_cmd;

    mrx_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .rail_a     (rail_a),
        .rail_b     (rail_b),
        .item_value (item_value),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_full     (q_full)
    );

    mrx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    mrx_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped_valid (popped_valid),
        .popped_value (popped_value)
    );

endmodule

`default_nettype wire

FILE: test/mrx_checker.sv
// ----------------------------------------------------------------------------
// mrx_checker
// Watches both channels of the XOR list engine, tracks the rails, the node
// pool and the free chain on every accepted item, and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mrx_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [1:0]         action,
    input  wire logic [3:0]         rail_a,
    input  wire logic [3:0]         rail_b,
    input  wire logic signed [31:0] item_value,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [2:0]         status,
    input  wire logic               popped_valid,
    input  wire logic signed [31:0] popped_value,
    output int                      fail_count,
    output int                      pending
);

    typedef struct packed {
        mrx_pkg::status_t st;
        logic             pv;
        logic [31:0]      val;
    } outcome_t;

    logic [mrx_pkg::VALUE_BITS-1:0] pool_value [mrx_pkg::POOL_NODES];
    logic [mrx_pkg::NODE_W-1:0]     pool_link  [mrx_pkg::POOL_NODES];
    logic [mrx_pkg::NODE_W-1:0]     head_of    [mrx_pkg::NUM_RAILS];
    logic [mrx_pkg::NODE_W-1:0]     tail_of    [mrx_pkg::NUM_RAILS];
    logic [mrx_pkg::FRESH_W-1:0]    next_fresh;
    logic [mrx_pkg::NODE_W-1:0]     free_head;
    outcome_t                       awaited [$];

    assign pending = awaited.size();

    function automatic outcome_t apply_action(input mrx_pkg::action_t act,
                                              input logic [3:0] ra,
                                              input logic [3:0] rb, input logic [31:0] v);
        outcome_t o;
        int a;
        int b;
        logic [mrx_pkg::NODE_W-1:0] n;
        logic [mrx_pkg::NODE_W-1:0] t;
        logic [mrx_pkg::NODE_W-1:0] p;
        logic [mrx_pkg::NODE_W-1:0] tb;
        o = '{mrx_pkg::ST_OK, 1'b0, 32'd0};
        a = ra % mrx_pkg::NUM_RAILS;
        b = rb % mrx_pkg::NUM_RAILS;
        case (act)
            mrx_pkg::ACT_ENTER:
            begin
                n = '0;
                if (free_head != 0)
                begin
                    n = free_head;
                    free_head = pool_link[n];
                end
                else if (next_fresh < mrx_pkg::POOL_NODES)
                begin
                    n = mrx_pkg::NODE_W'(next_fresh);
                    next_fresh++;
                end
                if (n == 0)
                    o.st = mrx_pkg::ST_POOL_FULL;
                else
                begin
                    t = tail_of[a];
                    pool_value[n] = v;
                    if (t != 0)
                    begin
                        pool_link[t] = pool_link[t] ^ n;
                        pool_link[n] = t;
                    end
                    else
                    begin
                        pool_link[n] = '0;
                        head_of[a] = n;
                    end
                    tail_of[a] = n;
                end
            end
            mrx_pkg::ACT_LEAVE:
            begin
                t = tail_of[a];
                if (head_of[a] == 0 || t == 0)
                    o.st = mrx_pkg::ST_POP_EMPTY;
                else
                begin
                    p = pool_link[t];
                    o.pv = 1'b1;
                    o.val = pool_value[t];
                    if (p != 0)
                    begin
                        pool_link[p] = pool_link[p] ^ t;
                        tail_of[a] = p;
                    end
                    else
                    begin
                        head_of[a] = '0;
                        tail_of[a] = '0;
                    end
                    pool_link[t] = free_head;
                    free_head = t;
                end
            end
            mrx_pkg::ACT_MIGRATE:
            begin
                if (a == b)
                    o.st = mrx_pkg::ST_SAME_RAIL;
                else if (head_of[a] == 0)
                    o.st = mrx_pkg::ST_SRC_EMPTY;
                else
                begin
                    t = tail_of[a];
                    tb = tail_of[b];
                    pool_link[t] = pool_link[t] ^ tb;
                    if (tb != 0)
                        pool_link[tb] = pool_link[tb] ^ t;
                    else
                        head_of[b] = t;
                    tail_of[b] = head_of[a];
                    head_of[a] = '0;
                    tail_of[a] = '0;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < mrx_pkg::NUM_RAILS; i++)
            begin
                head_of[i] = '0;
                tail_of[i] = '0;
            end
            next_fresh = 1;
            free_head = '0;
            fail_count = 0;
            awaited.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: status %0d popped %0b/%0d",
                                 status, popped_valid, popped_value);
                end
                else
                begin
                    e = awaited.pop_front();
                    if (status !== e.st || popped_valid !== e.pv
                        || popped_value !== e.val)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp %0d/%0b/%0d got %0d/%0b/%0d",
                                     e.st, e.pv, $signed(e.val),
                                     status, popped_valid, popped_value);
                    end
                end
            end
            if (in_valid && in_ready)
                awaited.push_back(apply_action(mrx_pkg::action_t'(action), rail_a,
                                               rail_b, item_value));
        end
    end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives push, pop and splice items into the XOR list engine with random
// gaps and result stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam int IDLE_LIMIT = 2000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         action;
    logic [3:0]         rail_a;
    logic [3:0]         rail_b;
    logic signed [31:0] item_value;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         status;
    logic               popped_valid;
    logic signed [31:0] popped_value;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;
    bit                 calm;
    int                 stall_left = 0;

    multi_rail_xor_list_engine DUT (.*);

    mrx_checker u_checker (.*);

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver stalls in bursts of random length.
    always @(negedge clk)
    begin
        if (calm || !rst_n)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 3);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Hold valid after acceptance; the next call drives new payload or a gap.
    task automatic send_item(input mrx_pkg::action_t act, input logic [3:0] ra,
                             input logic [3:0] rb, input logic [31:0] v);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        rail_a <= ra;
        rail_b <= rb;
        item_value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic mrx_pkg::action_t pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 47)
            return mrx_pkg::ACT_ENTER;
        else if (r < 87)
            return mrx_pkg::ACT_LEAVE;
        else if (r < 98)
            return mrx_pkg::ACT_MIGRATE;
        return mrx_pkg::ACT_NONE;
    endfunction

    initial
    begin
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = mrx_pkg::ACT_ENTER;
        rail_a = '0;
        rail_b = '0;
        item_value = '0;
        calm = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty cases, extremes of value and rail, splice, unused code.
        send_item(mrx_pkg::ACT_LEAVE, 4'd0, 4'd0, 32'd0);
        send_item(mrx_pkg::ACT_MIGRATE, 4'd3, 4'd3, 32'd0);
        send_item(mrx_pkg::ACT_MIGRATE, 4'd3, 4'd4, 32'd0);
        send_item(mrx_pkg::ACT_ENTER, 4'd0, 4'd9, 32'h8000_0000);
        send_item(mrx_pkg::ACT_ENTER, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_item(mrx_pkg::ACT_ENTER, 4'd15, 4'd15, 32'hFFFF_FFFF);
        send_item(mrx_pkg::ACT_ENTER, 4'd15, 4'd0, 32'd0);
        send_item(mrx_pkg::ACT_MIGRATE, 4'd0, 4'd15, 32'd0);
        send_item(mrx_pkg::ACT_MIGRATE, 4'd15, 4'd0, 32'hFFFF_FFFF);
        send_item(mrx_pkg::ACT_NONE, 4'd15, 4'd15, 32'hFFFF_FFFF);
        for (k = 0; k < 5; k++)
            send_item(mrx_pkg::ACT_LEAVE, 4'd0, 4'd5, 32'd0);
        send_item(mrx_pkg::ACT_LEAVE, 4'd15, 4'd0, 32'd0);

        // Fill the pool across rails until it reports full, then drain a bit.
        for (k = 0; k < 1026; k++)
            send_item(mrx_pkg::ACT_ENTER, 4'($urandom_range(0, 15)), 4'($urandom),
                      $urandom);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);

        for (k = 0; k < 510; k++)
        begin
            if (k == 430)
                calm = 1'b1;
            send_item(pick_action(), 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)), $urandom);
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
